// File: rtl/jhpr_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi heat plate package
// Shared widths, codes, request/response types and sequencer states.
// ----------------------------------------------------------------------------
package jhpr_pkg;

    localparam int CELL_W     = 23;
    localparam int EDGE_W     = 7;
    localparam int FUNC_W     = 2;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 23;

    localparam int GRID_SIZE_DEF = 20;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [EDGE_W-1:0] EDGE_TEMP_RST = 7'd100;
    localparam logic [CELL_W-1:0] STOP_RST      = 23'd6554;

    localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SWEEP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TEMP      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_in_req;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [CELL_W-1:0] max_diff;
        logic              converged;
    } t_out_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SWEEP,
        ST_DRAIN,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

// File: rtl/jhpr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module jhpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/jacobi_heat_plate_relaxation_unit.sv
// ----------------------------------------------------------------------------
// Jacobi heat plate relaxation unit
// Holds a square plate of fixed point temperatures in two ping-pong memories.
// Request channel (valid/ready): func 0 initializes the plate, func 1 runs one
// sweep, func 2 reads one cell. Every request gives one response carrying the
// cell value, the largest increase of the last sweep and the converged flag.
// Config channel (valid/ready, always ready): edge_temp, stop_threshold.
// Init writes every cell of both memories. A sweep makes five reads per
// interior cell (up, down, left, right, centre) through the single read
// port of the plate memory and writes the new value to the other memory.
// One request at a time; ready is low while a request is in progress.
// After reset an init pass over all GRID_SIZE^2 cells runs before the first
// request is taken. The response sits in an output register: a stalled
// receiver does not block the next request, only its completion.
// ----------------------------------------------------------------------------
module jacobi_heat_plate_relaxation_unit #(
    parameter int GRID_SIZE = jhpr_pkg::GRID_SIZE_DEF,
    parameter int FRAC_BITS = jhpr_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  jhpr_pkg::t_in_req                  i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output jhpr_pkg::t_out_rsp                 o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [jhpr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [jhpr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW    = jhpr_pkg::CELL_W;
    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(GRID_SIZE);
    localparam int XW    = jhpr_pkg::EDGE_W + FRAC_BITS + CW;

    localparam logic [2:0] PH_UP    = 3'd0;
    localparam logic [2:0] PH_DOWN  = 3'd1;
    localparam logic [2:0] PH_LEFT  = 3'd2;
    localparam logic [2:0] PH_RIGHT = 3'd3;
    localparam logic [2:0] PH_CTR   = 3'd4;

    jhpr_pkg::t_state r_state, n_state;

    logic [jhpr_pkg::EDGE_W-1:0] r_edge;
    logic [CW-1:0]               r_stop;
    logic [CW-1:0]               r_max_diff;
    logic                        r_sel;
    logic                        r_has_req;
    logic                        r_rd_ok;
    logic                        r_out_valid;
    logic [AW-1:0]               r_k;
    logic [RW-1:0]               r_i;
    logic [RW-1:0]               r_j;
    logic [2:0]                  r_ph;
    logic                        r_dv;
    logic                        r_wv;

    logic [2:0]                  r_dph;
    logic [AW-1:0]               r_dk;
    logic [AW-1:0]               r_wk;
    logic [CW+1:0]               r_acc;
    logic [CW-1:0]               r_v;
    logic [CW-1:0]               r_ctr;
    logic [CW-1:0]               r_cell;
    jhpr_pkg::t_out_rsp          r_out;

    logic                        w_in_acc;
    logic                        w_in_range;
    logic [AW-1:0]               w_cell_addr;
    logic                        w_last_cell;
    logic                        w_init_last;
    logic                        w_slot_free;
    logic                        w_drain_done;
    logic [XW-1:0]               w_edge_wide;
    logic [CW-1:0]               w_edge_fix;
    logic [CW-1:0]               w_pattern;
    logic [CW:0]                 w_diff;
    logic [CW-1:0]               w_rd0;
    logic [CW-1:0]               w_rd1;
    logic [CW-1:0]               w_rdata;
    logic [AW-1:0]               w_raddr;
    logic [AW-1:0]               w_waddr;
    logic [CW-1:0]               w_wdata;
    logic                        w_we0;
    logic                        w_we1;

    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_in_range   = (32'(i_in.row) < GRID_SIZE) && (32'(i_in.col) < GRID_SIZE);
    assign w_cell_addr  = w_in_range ? AW'(32'(i_in.row) * GRID_SIZE + 32'(i_in.col))
                                     : '0;
    assign w_last_cell  = (r_i == RW'(GRID_SIZE - 2)) && (r_j == RW'(GRID_SIZE - 2));
    assign w_init_last  = (r_k == AW'(CELLS - 1));
    assign w_slot_free  = !r_out_valid || i_out_ready;
    assign w_drain_done = !r_dv && !r_wv;

    assign w_edge_wide = XW'(r_edge) << FRAC_BITS;
    assign w_edge_fix  = (w_edge_wide > XW'({CW{1'b1}})) ? {CW{1'b1}}
                                                          : w_edge_wide[CW-1:0];
    assign w_pattern   = ((r_i == '0 || r_i == RW'(GRID_SIZE - 1)) &&
                          r_j != '0 && r_j != RW'(GRID_SIZE - 1)) ? w_edge_fix : '0;

    assign w_diff  = {1'b0, r_v} - {1'b0, r_ctr};
    assign w_rdata = r_sel ? w_rd1 : w_rd0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            jhpr_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_in.func)
                        jhpr_pkg::FUNC_INIT:  n_state = jhpr_pkg::ST_INIT;
                        jhpr_pkg::FUNC_SWEEP: n_state = jhpr_pkg::ST_SWEEP;
                        jhpr_pkg::FUNC_READ:  n_state = jhpr_pkg::ST_READ;
                        default:              n_state = jhpr_pkg::ST_DONE;
                    endcase
                end
            end
            jhpr_pkg::ST_INIT: begin
                if (w_init_last) begin
                    n_state = r_has_req ? jhpr_pkg::ST_DONE : jhpr_pkg::ST_IDLE;
                end
            end
            jhpr_pkg::ST_SWEEP: begin
                if (r_ph == PH_CTR && w_last_cell) begin
                    n_state = jhpr_pkg::ST_DRAIN;
                end
            end
            jhpr_pkg::ST_DRAIN: begin
                if (w_drain_done) begin
                    n_state = jhpr_pkg::ST_DONE;
                end
            end
            jhpr_pkg::ST_READ: begin
                n_state = jhpr_pkg::ST_DONE;
            end
            jhpr_pkg::ST_DONE: begin
                if (w_slot_free) begin
                    n_state = jhpr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jhpr_pkg::ST_IDLE;
            end
        endcase
    end

    // memory controls and handshake outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_raddr    = '0;
        w_waddr    = r_wk;
        w_wdata    = r_v;
        w_we0      = 1'b0;
        w_we1      = 1'b0;
        case (r_state)
            jhpr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                w_raddr    = w_cell_addr;
            end
            jhpr_pkg::ST_INIT: begin
                w_waddr = r_k;
                w_wdata = w_pattern;
                w_we0   = 1'b1;
                w_we1   = 1'b1;
            end
            jhpr_pkg::ST_SWEEP: begin
                case (r_ph)
                    PH_UP:    w_raddr = r_k - AW'(GRID_SIZE);
                    PH_DOWN:  w_raddr = r_k + AW'(GRID_SIZE);
                    PH_LEFT:  w_raddr = r_k - AW'(1);
                    PH_RIGHT: w_raddr = r_k + AW'(1);
                    default:  w_raddr = r_k;
                endcase
                w_we0 = r_wv && r_sel;
                w_we1 = r_wv && !r_sel;
            end
            jhpr_pkg::ST_DRAIN: begin
                w_we0 = r_wv && r_sel;
                w_we1 = r_wv && !r_sel;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jhpr_pkg::ST_INIT;
            r_edge      <= jhpr_pkg::EDGE_TEMP_RST;
            r_stop      <= jhpr_pkg::STOP_RST;
            r_max_diff  <= '0;
            r_sel       <= 1'b0;
            r_has_req   <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_ph        <= PH_UP;
            r_dv        <= 1'b0;
            r_wv        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= (r_state == jhpr_pkg::ST_SWEEP);
            r_wv    <= r_dv && (r_dph == PH_CTR);

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    jhpr_pkg::CFG_EDGE_TEMP:      r_edge <= i_cfg_data[jhpr_pkg::EDGE_W-1:0];
                    jhpr_pkg::CFG_STOP_THRESHOLD: r_stop <= i_cfg_data[CW-1:0];
                    default:                      r_stop <= r_stop;
                endcase
            end

            if (r_wv && !w_diff[CW] && (w_diff[CW-1:0] > r_max_diff)) begin
                r_max_diff <= w_diff[CW-1:0];
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                jhpr_pkg::ST_IDLE: begin
                    if (w_in_acc) begin
                        r_has_req <= 1'b1;
                        r_rd_ok   <= w_in_range;
                        if (i_in.func == jhpr_pkg::FUNC_INIT) begin
                            r_k        <= '0;
                            r_i        <= '0;
                            r_j        <= '0;
                            r_max_diff <= '0;
                        end else if (i_in.func == jhpr_pkg::FUNC_SWEEP) begin
                            r_k        <= AW'(GRID_SIZE + 1);
                            r_i        <= RW'(1);
                            r_j        <= RW'(1);
                            r_ph       <= PH_UP;
                            r_max_diff <= '0;
                        end
                    end
                end
                jhpr_pkg::ST_INIT: begin
                    r_k <= r_k + AW'(1);
                    if (r_j == RW'(GRID_SIZE - 1)) begin
                        r_j <= '0;
                        r_i <= r_i + RW'(1);
                    end else begin
                        r_j <= r_j + RW'(1);
                    end
                end
                jhpr_pkg::ST_SWEEP: begin
                    if (r_ph == PH_CTR) begin
                        r_ph <= PH_UP;
                        if (r_j == RW'(GRID_SIZE - 2)) begin
                            r_j <= RW'(1);
                            r_i <= r_i + RW'(1);
                            r_k <= r_k + AW'(3);
                        end else begin
                            r_j <= r_j + RW'(1);
                            r_k <= r_k + AW'(1);
                        end
                    end else begin
                        r_ph <= r_ph + 3'd1;
                    end
                end
                jhpr_pkg::ST_DRAIN: begin
                    if (w_drain_done) begin
                        r_sel <= !r_sel;
                    end
                end
                jhpr_pkg::ST_DONE: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_has_req <= r_has_req;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_dph <= r_ph;
        r_dk  <= r_k;
        if (r_dv) begin
            case (r_dph)
                PH_UP: begin
                    r_acc <= {2'b00, w_rdata};
                end
                PH_CTR: begin
                    r_v   <= r_acc[CW+1:2];
                    r_ctr <= w_rdata;
                    r_wk  <= r_dk;
                end
                default: begin
                    r_acc <= r_acc + {2'b00, w_rdata};
                end
            endcase
        end
        if (r_state == jhpr_pkg::ST_IDLE && w_in_acc) begin
            r_cell <= '0;
        end else if (r_state == jhpr_pkg::ST_READ) begin
            r_cell <= r_rd_ok ? w_rdata : '0;
        end
        if (r_state == jhpr_pkg::ST_DONE && w_slot_free) begin
            r_out.cell_value <= r_cell;
            r_out.max_diff   <= r_max_diff;
            r_out.converged  <= (r_max_diff <= r_stop);
        end
    end

    jhpr_ram #(
        .WIDTH (CW),
        .DEPTH (CELLS)
    ) u_ram0 (
        .i_clk   (i_clk),
        .i_we    (w_we0),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd0)
    );

    jhpr_ram #(
        .WIDTH (CW),
        .DEPTH (CELLS)
    ) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd1)
    );

`ifndef SYNTHESIS
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while a request is in progress");

    a_write_in_sweep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wv |-> (r_state == jhpr_pkg::ST_SWEEP || r_state == jhpr_pkg::ST_DRAIN))
        else $error("sweep write outside of sweep");

    a_phase_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jhpr_pkg::ST_SWEEP) |-> (r_ph <= PH_CTR))
        else $error("sweep phase out of range");

    a_raddr_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_raddr) < CELLS)
        else $error("plate read address out of range");
`endif

endmodule
